@@ src/nwu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nwu_pkg - shared types, codes and fixed-point helpers
// Request/response payloads, command and register codes, Q16.16 saturation
// helpers and the address reduction used by the weight update block.
// ============================================================================
package nwu_pkg;

    // Sizes
    localparam int NWU_NUM_WEIGHTS = 1024;
    localparam int INDEX_W         = 10;
    localparam int DATA_W          = 32;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int LR_W            = 31;
    localparam int CFG_INDEX_W     = 1;
    localparam int NWU_FIFO_DEPTH  = 8;

    // Register reset values
    localparam logic [LR_W-1:0] LR_RESET = 31'd655;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Learning rule codes
    localparam logic RULE_DELTA = 1'b0;
    localparam logic RULE_OJA   = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_SELECT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEARNING_RATE = 1'b1;

    // Q16.16 limits
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     cmd;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] scalar;
    } nwu_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] weight_out;
        logic [INDEX_W-1:0]       index_out;
        logic                     saturated;
    } nwu_rsp_t;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] value;
    } nwu_sat_t;

    // Product shifted right by 16 (towards minus infinity), clipped to 32 bits
    function automatic nwu_sat_t nwu_sat_q16(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] sh;
        nwu_sat_t                 r;
        sh = prod >>> 16;
        if (sh[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){sh[DATA_W-1]}}) begin
            r.clip  = 1'b0;
            r.value = sh[DATA_W-1:0];
        end
        else begin
            r.clip  = 1'b1;
            r.value = sh[PROD_W-1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    // 33-bit sum or difference clipped to 32 bits
    function automatic nwu_sat_t nwu_sat_sum(input logic signed [DATA_W:0] s);
        nwu_sat_t r;
        if (s[DATA_W] == s[DATA_W-1]) begin
            r.clip  = 1'b0;
            r.value = s[DATA_W-1:0];
        end
        else begin
            r.clip  = 1'b1;
            r.value = s[DATA_W] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    // Index modulo the store depth: restoring compare/subtract on 10 bits
    function automatic logic [INDEX_W-1:0] nwu_reduce_index(input logic [INDEX_W-1:0] idx,
                                                            input int unsigned num);
        logic [INDEX_W-1:0] r;
        logic [63:0]        step;
        r = idx;
        for (int i = INDEX_W - 1; i >= 0; i--) begin
            step = 64'(num) << i;
            if ((step < (64'd1 << INDEX_W)) && (64'(r) >= step)) begin
                r = r - step[INDEX_W-1:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/neuron_weight_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// neuron_weight_update - weight store with delta-rule / Oja-rule update
// Loads or updates one Q16.16 weight per request and returns the new value.
// ============================================================================
// One request per clock is taken while response space is free and no
// update hazard holds it back, and each one gives one response, which passes
// through the pipeline stages into the response buffer. The weights live in a
// synchronous RAM that is read when a request is taken and written from the
// write stage, after three pipelined multiplies (lr*scalar with the request,
// then scalar*w, then k*m). A write from the cycle just before is forwarded;
// an update whose address matches a load or update still in the first three
// stages waits until that one reaches the write stage, so back-to-back
// accesses to one weight stall the request channel. Eight responses can be
// buffered; requests are taken while space for their response is reserved.
// An update of a weight that was never loaded returns an undefined value.
module neuron_weight_update
    import nwu_pkg::*;
#(
    parameter int NUM_WEIGHTS = NWU_NUM_WEIGHTS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request channel
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire nwu_req_t               req_data,
    // response channel
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output nwu_rsp_t                    rsp_data,
    // register writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LR_W-1:0]        cfg_data
);

    localparam int ADDR_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int CNT_W  = $clog2(NWU_FIFO_DEPTH + 1);

    typedef struct packed {
        logic                     cmd;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] s;
        logic signed [PROD_W-1:0] kp;
    } st1_t;

    typedef struct packed {
        logic                     cmd;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] k;
        logic                     clip;
        logic signed [PROD_W-1:0] pp;
    } st2_t;

    typedef struct packed {
        logic                     cmd;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] k;
        logic signed [DATA_W-1:0] m;
        logic                     clip;
    } st3_t;

    typedef struct packed {
        logic                     cmd;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] w;
        logic                     clip;
        logic signed [PROD_W-1:0] dp;
    } st4_t;

    // Registers
    logic                     rule_select_reg, rule_select_next;
    logic [LR_W-1:0]          learning_rate_reg, learning_rate_next;
    logic [4:1]               vld_reg, vld_next;
    st1_t                     st1_reg, st1_next;
    st2_t                     st2_reg, st2_next;
    st3_t                     st3_reg, st3_next;
    st4_t                     st4_reg, st4_next;
    logic                     wb_vld_reg, wb_vld_next;
    logic [INDEX_W-1:0]       wb_idx_reg, wb_idx_next;
    logic signed [DATA_W-1:0] wb_data_reg, wb_data_next;
    logic [CNT_W-1:0]         pending_reg, pending_next;

    // Combinational
    logic [INDEX_W-1:0]       req_idx;
    logic                     hazard;
    logic                     req_acc;
    logic                     rsp_pop;
    logic signed [PROD_W-1:0] kp0;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] w1;
    nwu_sat_t                 ksat;
    nwu_sat_t                 psat;
    nwu_sat_t                 msat;
    nwu_sat_t                 dsat;
    nwu_sat_t                 ssat;
    logic signed [DATA_W:0]   diff2;
    logic signed [DATA_W:0]   sum4;
    nwu_rsp_t                 rsp_push;

    // ------------------------------------------------------------------
    // Register writes
    // ------------------------------------------------------------------
    always_comb
    begin
        rule_select_next   = rule_select_reg;
        learning_rate_next = learning_rate_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RULE_SELECT:   rule_select_next   = cfg_data[0];
                CFG_LEARNING_RATE: learning_rate_next = cfg_data;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request intake: address reduction, hazard check, lr*scalar
    // ------------------------------------------------------------------
    assign req_idx = nwu_reduce_index(req_data.index, NUM_WEIGHTS);

    // An update must not read a weight still being worked on in stages 1..3
    assign hazard = (req_data.cmd == CMD_UPDATE) &&
                    ((vld_reg[1] && (st1_reg.idx == req_idx)) ||
                     (vld_reg[2] && (st2_reg.idx == req_idx)) ||
                     (vld_reg[3] && (st3_reg.idx == req_idx)));

    assign req_ready = (pending_reg < CNT_W'(NWU_FIFO_DEPTH)) && !hazard;
    assign req_acc   = req_valid && req_ready;
    assign rsp_pop   = rsp_valid && rsp_ready;

    assign kp0 = PROD_W'($signed({1'b0, learning_rate_reg})) * PROD_W'(req_data.scalar);

    always_comb
    begin
        st1_next.cmd = req_data.cmd;
        st1_next.idx = req_idx;
        st1_next.x   = req_data.value;
        st1_next.s   = req_data.scalar;
        st1_next.kp  = kp0;
    end

    // ------------------------------------------------------------------
    // Weight RAM
    // ------------------------------------------------------------------
    nwu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_WEIGHTS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (vld_reg[4]),
        .waddr (ADDR_W'(st4_reg.idx)),
        .wdata (rsp_push.weight_out),
        .re    (req_acc),
        .raddr (ADDR_W'(req_idx)),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: weight with forwarding, k = sat(lr*s), scalar*w
    // ------------------------------------------------------------------
    assign w1   = (wb_vld_reg && (wb_idx_reg == st1_reg.idx)) ? wb_data_reg
                                                              : $signed(ram_rdata);
    assign ksat = nwu_sat_q16(st1_reg.kp);

    always_comb
    begin
        st2_next.cmd  = st1_reg.cmd;
        st2_next.idx  = st1_reg.idx;
        st2_next.x    = st1_reg.x;
        st2_next.w    = w1;
        st2_next.k    = ksat.value;
        st2_next.clip = ksat.clip;
        st2_next.pp   = PROD_W'(st1_reg.s) * PROD_W'(w1);
    end

    // ------------------------------------------------------------------
    // Stage 2: m = x (delta) or sat(x - sat(y*w)) (Oja); loads carry x
    // ------------------------------------------------------------------
    assign psat  = nwu_sat_q16(st2_reg.pp);
    assign diff2 = {st2_reg.x[DATA_W-1], st2_reg.x} - {psat.value[DATA_W-1], psat.value};
    assign msat  = nwu_sat_sum(diff2);

    always_comb
    begin
        st3_next.cmd = st2_reg.cmd;
        st3_next.idx = st2_reg.idx;
        st3_next.w   = (st2_reg.cmd == CMD_LOAD) ? st2_reg.x : st2_reg.w;
        st3_next.k   = st2_reg.k;
        if (rule_select_reg == RULE_OJA)
        begin
            st3_next.m    = msat.value;
            st3_next.clip = st2_reg.clip | psat.clip | msat.clip;
        end
        else
        begin
            st3_next.m    = st2_reg.x;
            st3_next.clip = st2_reg.clip;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: k*m
    // ------------------------------------------------------------------
    always_comb
    begin
        st4_next.cmd  = st3_reg.cmd;
        st4_next.idx  = st3_reg.idx;
        st4_next.w    = st3_reg.w;
        st4_next.clip = st3_reg.clip;
        st4_next.dp   = PROD_W'(st3_reg.k) * PROD_W'(st3_reg.m);
    end

    // ------------------------------------------------------------------
    // Stage 4: w' = sat(w + sat(k*m)), write back and queue the response
    // ------------------------------------------------------------------
    assign dsat = nwu_sat_q16(st4_reg.dp);
    assign sum4 = {st4_reg.w[DATA_W-1], st4_reg.w} + {dsat.value[DATA_W-1], dsat.value};
    assign ssat = nwu_sat_sum(sum4);

    always_comb
    begin
        rsp_push.index_out = st4_reg.idx;
        if (st4_reg.cmd == CMD_UPDATE)
        begin
            rsp_push.weight_out = ssat.value;
            rsp_push.saturated  = st4_reg.clip | dsat.clip | ssat.clip;
        end
        else
        begin
            rsp_push.weight_out = st4_reg.w;
            rsp_push.saturated  = 1'b0;
        end
    end

    // Last write, forwarded to the stage 1 read
    always_comb
    begin
        wb_vld_next  = vld_reg[4];
        wb_idx_next  = st4_reg.idx;
        wb_data_next = rsp_push.weight_out;
    end

    // ------------------------------------------------------------------
    // Control: valids and reserved response slots
    // ------------------------------------------------------------------
    always_comb
    begin
        vld_next     = {vld_reg[3:1], req_acc};
        pending_next = pending_reg + CNT_W'(req_acc) - CNT_W'(rsp_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_select_reg   <= RULE_DELTA;
            learning_rate_reg <= LR_RESET;
            vld_reg           <= '0;
            wb_vld_reg        <= 1'b0;
            pending_reg       <= '0;
        end
        else
        begin
            rule_select_reg   <= rule_select_next;
            learning_rate_reg <= learning_rate_next;
            vld_reg           <= vld_next;
            wb_vld_reg        <= wb_vld_next;
            pending_reg       <= pending_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        st1_reg     <= st1_next;
        st2_reg     <= st2_next;
        st3_reg     <= st3_next;
        st4_reg     <= st4_next;
        wb_idx_reg  <= wb_idx_next;
        wb_data_reg <= wb_data_next;
    end

    // ------------------------------------------------------------------
    // Response buffer
    // ------------------------------------------------------------------
    nwu_out_fifo #(
        .DEPTH (NWU_FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (vld_reg[4]),
        .push_data (rsp_push),
        .pop       (rsp_pop),
        .data      (rsp_data),
        .not_empty (rsp_valid)
    );

endmodule
`default_nettype wire

@@ src/nwu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nwu_ram - generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data registered, read-first on a
// collision with a write to the same address.
// ============================================================================
module nwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= ram_reg[raddr];
        end
    end

endmodule
`default_nettype wire

@@ src/nwu_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nwu_out_fifo - response buffer
// Small register FIFO that decouples the free-running update pipeline from
// response back-pressure. Space is reserved upstream, so it never overflows.
// ============================================================================
module nwu_out_fifo
    import nwu_pkg::*;
#(
    parameter int DEPTH = NWU_FIFO_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire nwu_rsp_t push_data,
    input  wire logic     pop,
    output nwu_rsp_t      data,
    output logic          not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nwu_rsp_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign data      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule
`default_nettype wire

@@ src/nwu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nwu_port_checks - port-level checks for neuron_weight_update
// Watches the request and response channels only; bound to the top level.
// ============================================================================
module nwu_port_checks
    import nwu_pkg::*;
#(
    parameter int NUM_WEIGHTS = NWU_NUM_WEIGHTS
) (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire nwu_rsp_t rsp_data
);

    logic req_acc;

    assign req_acc = req_valid && req_ready;

    // A stalled response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response withdrawn before it was taken");

    // A stalled response keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("response payload changed while stalled");

    // Returned address is always reduced into the store
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_data.index_out) < NUM_WEIGHTS))
        else $error("response index outside the weight store");

    // No response appears unless a request was taken within the pipeline depth
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rsp_valid) && !$past(req_acc, 1) && !$past(req_acc, 2) &&
        !$past(req_acc, 3) && !$past(req_acc, 4) && !$past(req_acc, 5)
        |-> !rsp_valid)
        else $error("response without a matching request");

endmodule

bind neuron_weight_update nwu_port_checks #(
    .NUM_WEIGHTS (NUM_WEIGHTS)
) u_nwu_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
`default_nettype wire

@@ tb/nwu_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nwu_checker - response checker for the neuron weight update block
// Watches the request, response and register ports, keeps its own copy of
// the weight store and of the rule settings, works out the weight that each
// accepted request leaves behind and checks the responses against it, in order.
// ============================================================================
module nwu_checker
    import nwu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    input  wire logic                   req_ready,
    input  wire nwu_req_t               req_data,
    input  wire logic                   rsp_valid,
    input  wire logic                   rsp_ready,
    input  wire nwu_rsp_t               rsp_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LR_W-1:0]        cfg_data,
    output int                          mismatches,
    output int                          outstanding
);

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    logic signed [DATA_W-1:0] weight_copy [NWU_NUM_WEIGHTS];
    logic                     rule_copy;
    logic [LR_W-1:0]          rate_copy;
    nwu_rsp_t                 weights_due [$];
    nwu_rsp_t                 due;

    // Clip to the signed 32-bit range, noting any clipping
    function automatic longint clamp_word(input longint v, inout bit clipped);
        if (v > WORD_MAX)
        begin
            clipped = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            clipped = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // New weight for one request; updates the local weight copy
    function automatic nwu_rsp_t apply_weight_rule(input nwu_req_t r);
        nwu_rsp_t           res;
        logic [INDEX_W-1:0] addr;
        longint             x;
        longint             y;
        longint             w;
        longint             rate;
        longint             k;
        longint             p;
        longint             m;
        longint             d;
        bit                 clipped;
        addr    = INDEX_W'(r.index % NWU_NUM_WEIGHTS);
        x       = r.value;
        y       = r.scalar;
        rate    = rate_copy;
        clipped = 1'b0;
        if (r.cmd == CMD_LOAD)
        begin
            w = x;
        end
        else
        begin
            w = weight_copy[addr];
            k = clamp_word((rate * y) >>> 16, clipped);
            // delta rule scales x directly; Oja's rule scales x - y*w
            if (rule_copy == RULE_DELTA)
            begin
                m = x;
            end
            else
            begin
                p = clamp_word((y * w) >>> 16, clipped);
                m = clamp_word(x - p, clipped);
            end
            d = clamp_word((k * m) >>> 16, clipped);
            w = clamp_word(w + d, clipped);
        end
        weight_copy[addr] = DATA_W'(w);
        res.weight_out    = DATA_W'(w);
        res.index_out     = addr;
        res.saturated     = clipped;
        return res;
    endfunction

    // Register writes, response check, then the new request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_copy = RULE_DELTA;
            rate_copy = LR_RESET;
            weights_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RULE_SELECT:   rule_copy = cfg_data[0];
                    CFG_LEARNING_RATE: rate_copy = cfg_data;
                    default:           ;
                endcase
            end

            if (rsp_valid && rsp_ready)
            begin
                if (weights_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: response with no request outstanding: expected none, got %h",
                             $time, rsp_data);
                end
                else
                begin
                    due = weights_due.pop_front();
                    if (rsp_data.weight_out !== due.weight_out)
                    begin
                        mismatches++;
                        $display("%0t: weight_out (index %0d): expected %h, got %h",
                                 $time, due.index_out, due.weight_out, rsp_data.weight_out);
                    end
                    if (rsp_data.index_out !== due.index_out)
                    begin
                        mismatches++;
                        $display("%0t: index_out: expected %0d, got %0d",
                                 $time, due.index_out, rsp_data.index_out);
                    end
                    if (rsp_data.saturated !== due.saturated)
                    begin
                        mismatches++;
                        $display("%0t: saturated (index %0d): expected %b, got %b",
                                 $time, due.index_out, due.saturated, rsp_data.saturated);
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                weights_due.push_back(apply_weight_rule(req_data));
            end
            outstanding <= weights_due.size();
        end
    end

endmodule

@@ tb/tb_neuron_weight_update.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_neuron_weight_update - regression for the neuron weight update block
// Drives load and update requests under both learning rules and a range of
// learning rates, with random idling on both channels and one long response
// stall; the checker beside the block predicts and compares every response.
// ============================================================================
module tb_neuron_weight_update;
    import nwu_pkg::*;

    localparam int SEGMENT_ITEMS   = 67;   // random items per setting in each idling phase
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 8;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    nwu_req_t               req_data  = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    nwu_rsp_t               rsp_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_RULE_SELECT;
    logic [LR_W-1:0]        cfg_data  = '0;

    int                     mismatches;
    int                     outstanding;
    int                     send_idle_pct  = 0;
    int                     rcv_idle_pct   = 0;
    int                     hold_off_asked = 0;
    bit                     loaded [NWU_NUM_WEIGHTS];
    int                     loaded_list [$];
    logic [INDEX_W-1:0]     last_index = '0;

    always #5 clk = ~clk;

    neuron_weight_update #(
        .NUM_WEIGHTS (NWU_NUM_WEIGHTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nwu_checker weight_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog
    initial
    begin
        #(5_000_000);
        $display("neuron_weight_update regression: fail");
        $finish;
    end

    // Response side: random stalls, plus a long hold-off when asked
    initial
    begin
        int hold_off_served;
        int hold_left;
        hold_off_served = 0;
        hold_left       = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_off_served != hold_off_asked)
            begin
                hold_off_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    function automatic nwu_req_t make_req(input logic cmd, input int idx,
                                          input logic [DATA_W-1:0] value,
                                          input logic [DATA_W-1:0] scalar);
        nwu_req_t r;
        r.cmd    = cmd;
        r.index  = INDEX_W'(idx);
        r.value  = value;
        r.scalar = scalar;
        return r;
    endfunction

    // Q16.16 operand: full range, edge values or small magnitudes
    function automatic logic [DATA_W-1:0] rand_fixed();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:
            begin
                case ($urandom_range(5))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return '1;
                    4:       return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            default: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [LR_W-1:0] pick_rate(input int sel);
        case (sel % 6)
            0:       return LR_RESET;
            1:       return 31'h0001_0000;
            2:       return '1;
            3:       return '0;
            4:       return LR_W'($urandom);
            default: return LR_W'($urandom_range(32'h0002_0000));
        endcase
    endfunction

    // One request: optional idle gap, then hold valid until taken
    task automatic send_req(input nwu_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (!req_ready);
        if (!loaded[r.index])
        begin
            loaded[r.index] = 1'b1;
            loaded_list.push_back(r.index);
        end
        last_index = r.index;
    endtask

    // Loads to a hot range or anywhere; updates only hit loaded weights,
    // often the one just touched to exercise the hazard path
    task automatic send_random_item();
        nwu_req_t r;
        r.value  = rand_fixed();
        r.scalar = rand_fixed();
        if (loaded_list.size() == 0 || $urandom_range(99) < 25)
        begin
            r.cmd   = CMD_LOAD;
            r.index = ($urandom_range(99) < 50) ? INDEX_W'($urandom_range(15))
                                                : INDEX_W'($urandom);
        end
        else
        begin
            r.cmd   = CMD_UPDATE;
            r.index = ($urandom_range(99) < 35) ? last_index
                      : INDEX_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
        end
        send_req(r);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LR_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stop offering and wait for every response, then the pipeline depth
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // delta rule at reset settings: extremes, saturation both ways, hazards
        send_req(make_req(CMD_LOAD,   0,    Q_MAX,        '0));
        send_req(make_req(CMD_LOAD,   1023, Q_MIN,        '0));
        send_req(make_req(CMD_LOAD,   512,  '0,           '0));
        send_req(make_req(CMD_LOAD,   7,    32'h0001_0000, '0));
        send_req(make_req(CMD_UPDATE, 0,    Q_MAX,        Q_MAX));
        send_req(make_req(CMD_UPDATE, 1023, Q_MAX,        Q_MIN));
        send_req(make_req(CMD_UPDATE, 512,  '0,           '0));
        send_req(make_req(CMD_UPDATE, 7,    32'h0002_0000, 32'hFFFE_8000));
        send_req(make_req(CMD_UPDATE, 7,    32'h0002_0000, 32'h0100_0000));
        send_req(make_req(CMD_UPDATE, 7,    32'hFFFF_0000, 32'h0100_0000));
        send_req(make_req(CMD_LOAD,   7,    32'h0000_8000, '0));
        send_req(make_req(CMD_UPDATE, 7,    32'h0001_0000, 32'h0010_0000));
        settle();

        // Oja's rule at the largest learning rate
        write_reg(CFG_LEARNING_RATE, '1);
        write_reg(CFG_RULE_SELECT, RULE_OJA);
        send_req(make_req(CMD_LOAD,   3,    Q_MIN,        '0));
        send_req(make_req(CMD_UPDATE, 3,    Q_MAX,        Q_MIN));
        send_req(make_req(CMD_LOAD,   4,    Q_MAX,        '0));
        send_req(make_req(CMD_UPDATE, 4,    Q_MIN,        32'h0001_0000));
        send_req(make_req(CMD_UPDATE, 512,  Q_MAX,        '0));
        send_req(make_req(CMD_LOAD,   9,    32'h0000_8000, '0));
        send_req(make_req(CMD_UPDATE, 9,    32'h0001_0000, 32'h0000_4000));
        send_req(make_req(CMD_UPDATE, 9,    32'hFFFF_0000, 32'hFFFF_C000));
        settle();

        // random requests: three idling phases, four settings each
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int seg = 0; seg < 4; seg++)
            begin
                settle();
                if (seg == 0)
                begin
                    send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 54 : 0;
                    rcv_idle_pct  = (ph == 0) ? 54 : (ph == 1) ? 9 : 0;
                end
                write_reg(CFG_RULE_SELECT, LR_W'((seg + ph) % 2));
                write_reg(CFG_LEARNING_RATE, pick_rate(ph * 4 + seg));
                // long response stall while requests keep coming
                if (ph == 2 && seg == 1)
                begin
                    hold_off_asked++;
                end
                repeat (SEGMENT_ITEMS) send_random_item();
            end
        end
        settle();

        if (mismatches == 0)
        begin
            $display("neuron_weight_update regression: pass");
        end
        else
        begin
            $display("neuron_weight_update regression: fail");
        end
        $finish;
    end

endmodule
